// ----- sv/gif_hfc_pkg.sv -----
// Package for the GIF header/footer carver.
// Byte codes of the GIF signature and trailer, and the result burst kinds.
// No dependencies.
package gif_hfc_pkg;

  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] BYTE_TRAILER = 8'h3B;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_I       = 8'h49;
  localparam logic [7:0] CHAR_F       = 8'h46;
  localparam logic [7:0] CHAR_8       = 8'h38;
  localparam logic [7:0] CHAR_7       = 8'h37;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_A       = 8'h61;

  localparam int unsigned       MAX_RESULTS   = 6;
  localparam logic [15:0]       MAX_SIZE_RST  = 16'd4000;
  localparam logic [2:0]        HDR_RESULTS   = 3'd6;
  localparam logic [2:0]        FORCE_RESULTS = 3'd3;
  localparam logic [2:0]        ONE_RESULT    = 3'd1;

  // Kind of result burst held in the output buffer
  typedef enum logic [1:0] {
    BURST_HEADER,
    BURST_PASS,
    BURST_TRAILER,
    BURST_FORCED
  } burst_kind_t;

endpackage

// ----- sv/gif_header_footer_carver_unit.sv -----
// GIF header/footer carver, top level.
// Depends on gif_hfc_pkg for byte codes and the burst kind type.
//
// Usage:
//   in_valid/in_ready move one raw image byte (in_data_byte) per transaction.
//   out_valid/out_ready move one carved byte with its flags per transaction.
//   cfg_valid/cfg_ready write max_file_size; cfg_ready is always high, and
//   writes are meant to land only while the block is idle.
// Each accepted byte updates the carver state in the cycle it is taken and
// loads its results (none, one, three or six) into an output buffer. The
// first result appears in the cycle after acceptance and the buffer drains one
// result per cycle while out_ready is high. Throughput is one byte per cycle
// while carving or searching and nothing stalls; after a header match or a
// forced close, input waits while the single output port drains the buffer.
// in_ready is high when the buffer is empty or its last result is being taken
// this cycle. A stalled receiver holds the buffer and therefore the input.
// Reset (rst_n low, synchronous) empties the buffer, returns to searching,
// clears history, size and file counters, and loads max_file_size = 4000.
module gif_header_footer_carver_unit
  import gif_hfc_pkg::*;
#(
  parameter int COUNT_BITS       = 16,
  parameter int FILE_NUMBER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_file_start,
  output logic        out_file_end,
  output logic        out_forced_end,
  output logic [15:0] out_file_number,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // carver state
  logic [15:0]                 max_size_r;
  logic [39:0]                 history_r, history_nxt;
  logic                        carving_r, carving_nxt;
  logic                        prev_zero_r, prev_zero_nxt;
  logic [COUNT_BITS-1:0]       size_r, size_nxt;
  logic [FILE_NUMBER_BITS-1:0] file_cnt_r, file_cnt_nxt;

  // output buffer
  logic                        busy_r;
  logic [2:0]                  count_r;
  logic [2:0]                  idx_r;
  burst_kind_t                 kind_r;
  logic [7:0]                  bytes_r [MAX_RESULTS];
  logic [FILE_NUMBER_BITS-1:0] fnum_r;

  logic                        in_fire, out_fire, pop_last;
  logic                        match, trailer_hit, over_limit, has_results;
  logic [COUNT_BITS-1:0]       size_inc;
  burst_kind_t                 kind_nxt;
  logic [2:0]                  count_nxt;
  logic [7:0]                  bytes_nxt [MAX_RESULTS];
  logic [FILE_NUMBER_BITS+15:0] fnum_ext;

  assign cfg_ready = 1'b1;
  assign out_fire  = out_valid && out_ready;
  assign pop_last  = out_fire && (idx_r == count_r - 3'd1);
  assign in_ready  = !busy_r || pop_last;
  assign in_fire   = in_valid && in_ready;

  assign match = !carving_r &&
                 history_r[39:32] == CHAR_G && history_r[31:24] == CHAR_I &&
                 history_r[23:16] == CHAR_F && history_r[15:8] == CHAR_8 &&
                 (history_r[7:0] == CHAR_7 || history_r[7:0] == CHAR_9) &&
                 in_data_byte == CHAR_A;

  assign size_inc    = (size_r != COUNT_MAX) ? size_r + 1'b1 : size_r;
  assign trailer_hit = prev_zero_r && in_data_byte == BYTE_TRAILER;
  assign over_limit  = CMP_W'(size_inc) > CMP_W'(max_size_r);
  assign has_results = carving_r || match;

  always_comb begin
    history_nxt   = history_r;
    carving_nxt   = carving_r;
    prev_zero_nxt = prev_zero_r;
    size_nxt      = size_r;
    file_cnt_nxt  = file_cnt_r;
    kind_nxt      = BURST_PASS;
    count_nxt     = ONE_RESULT;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bytes_nxt[i] = BYTE_ZERO;
    end
    if (!carving_r) begin
      if (match) begin
        history_nxt   = '0;
        carving_nxt   = 1'b1;
        prev_zero_nxt = 1'b0;
        size_nxt      = COUNT_BITS'(HDR_RESULTS);
        kind_nxt      = BURST_HEADER;
        count_nxt     = HDR_RESULTS;
        bytes_nxt[0]  = history_r[39:32];
        bytes_nxt[1]  = history_r[31:24];
        bytes_nxt[2]  = history_r[23:16];
        bytes_nxt[3]  = history_r[15:8];
        bytes_nxt[4]  = history_r[7:0];
        bytes_nxt[5]  = in_data_byte;
      end else begin
        history_nxt = {history_r[31:0], in_data_byte};
      end
    end else begin
      bytes_nxt[0] = in_data_byte;
      bytes_nxt[1] = BYTE_ZERO;
      bytes_nxt[2] = BYTE_TRAILER;
      if (trailer_hit || over_limit) begin
        // close the file
        carving_nxt   = 1'b0;
        prev_zero_nxt = 1'b0;
        size_nxt      = '0;
        history_nxt   = '0;
        file_cnt_nxt  = file_cnt_r + 1'b1;
        kind_nxt      = trailer_hit ? BURST_TRAILER : BURST_FORCED;
        count_nxt     = trailer_hit ? ONE_RESULT : FORCE_RESULTS;
      end else begin
        size_nxt      = size_inc;
        prev_zero_nxt = (in_data_byte == BYTE_ZERO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r  <= MAX_SIZE_RST;
      history_r   <= '0;
      carving_r   <= 1'b0;
      prev_zero_r <= 1'b0;
      size_r      <= '0;
      file_cnt_r  <= '0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      count_r     <= ONE_RESULT;
      kind_r      <= BURST_PASS;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_size_r <= cfg_data;
      end
      if (in_fire) begin
        history_r   <= history_nxt;
        carving_r   <= carving_nxt;
        prev_zero_r <= prev_zero_nxt;
        size_r      <= size_nxt;
        file_cnt_r  <= file_cnt_nxt;
      end
      if (in_fire && has_results) begin
        busy_r  <= 1'b1;
        idx_r   <= '0;
        count_r <= count_nxt;
        kind_r  <= kind_nxt;
      end else if (pop_last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // payload of the buffer, no reset
  always_ff @(posedge clk) begin
    if (in_fire && has_results) begin
      bytes_r <= bytes_nxt;
      fnum_r  <= file_cnt_r;
    end
  end

  assign fnum_ext        = {16'b0, fnum_r};
  assign out_valid       = busy_r;
  assign out_byte        = bytes_r[idx_r];
  assign out_file_start  = (kind_r == BURST_HEADER) && (idx_r == 3'd0);
  assign out_file_end    = (kind_r == BURST_TRAILER) ||
                           ((kind_r == BURST_FORCED) && (idx_r == 3'd2));
  assign out_forced_end  = (kind_r == BURST_FORCED) && (idx_r != 3'd0);
  assign out_file_number = fnum_ext[15:0];
  assign out_last        = (idx_r == count_r - 3'd1);

  // buffer index stays inside the burst
  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < count_r)
    else $error("output index beyond burst length");

  // input is taken while busy only as the last result drains
  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && in_ready) |-> (out_ready && out_last))
    else $error("input accepted while results still pending");

  // a forced close leaves the carver searching with a three-result burst
  a_forced_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && carving_r && !trailer_hit && over_limit) |=>
      (!carving_r && busy_r && kind_r == BURST_FORCED && count_r == FORCE_RESULTS))
    else $error("forced close did not end the file");

  // a file start is always the head of a six-byte header burst
  a_start_header: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_file_start) |-> (count_r == HDR_RESULTS && carving_r ||
                                    count_r == HDR_RESULTS && !carving_r))
    else $error("file start outside a header burst");

endmodule

// ----- test/gif_hfc_carve_checker.sv -----
// Checker for the GIF header/footer carver: watches the byte, result and limit
// channels, predicts every carved byte and compares the results field by field.
// Depends on gif_hfc_pkg for the signature, trailer and reset limit constants.
module gif_hfc_carve_checker
  import gif_hfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_file_start,
  input  logic        out_file_end,
  input  logic        out_forced_end,
  input  logic [15:0] out_file_number,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          bytes_owed
);

  typedef struct packed {
    logic [7:0]  data;
    logic        starts;
    logic        ends;
    logic        forced;
    logic [15:0] number;
    logic        last;
  } carved_byte_t;

  carved_byte_t carved_q[$];

  logic [39:0] history;
  logic        carving;
  logic        prev_zero;
  logic [15:0] size_count;
  logic [15:0] file_count;
  logic [15:0] size_limit;
  int          errors = 0;

  assign mismatches = errors;

  task automatic emit(input logic [7:0] data, input logic starts, input logic ends,
                      input logic forced, input logic last);
    carved_byte_t item;
    item = '{data, starts, ends, forced, file_count, last};
    carved_q.insert(carved_q.size(), item);
  endtask

  task automatic close_file();
    carving    = 1'b0;
    prev_zero  = 1'b0;
    size_count = '0;
    history    = '0;
    file_count = file_count + 16'd1;
  endtask

  // Advance the carver by one image byte and queue the bytes it emits
  task automatic carve_byte(input logic [7:0] b);
    logic hit;
    if (!carving) begin
      hit = history[39:32] == CHAR_G && history[31:24] == CHAR_I &&
            history[23:16] == CHAR_F && history[15:8] == CHAR_8 &&
            (history[7:0] == CHAR_7 || history[7:0] == CHAR_9) && b == CHAR_A;
      if (!hit) begin
        history = {history[31:0], b};
      end else begin
        emit(history[39:32], 1'b1, 1'b0, 1'b0, 1'b0);
        emit(history[31:24], 1'b0, 1'b0, 1'b0, 1'b0);
        emit(history[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
        emit(history[15:8],  1'b0, 1'b0, 1'b0, 1'b0);
        emit(history[7:0],   1'b0, 1'b0, 1'b0, 1'b0);
        emit(b,              1'b0, 1'b0, 1'b0, 1'b1);
        history    = '0;
        carving    = 1'b1;
        prev_zero  = 1'b0;
        size_count = 16'd6;
      end
    end else begin
      // saturate, never wrap
      if (size_count != 16'hFFFF) size_count = size_count + 16'd1;
      if (prev_zero && b == BYTE_TRAILER) begin
        emit(b, 1'b0, 1'b1, 1'b0, 1'b1);
        close_file();
      end else if (size_count > size_limit) begin
        emit(b,            1'b0, 1'b0, 1'b0, 1'b0);
        emit(BYTE_ZERO,    1'b0, 1'b0, 1'b1, 1'b0);
        emit(BYTE_TRAILER, 1'b0, 1'b1, 1'b1, 1'b1);
        close_file();
      end else begin
        emit(b, 1'b0, 1'b0, 1'b0, 1'b1);
        prev_zero = (b == BYTE_ZERO);
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    carved_byte_t want;
    if (carved_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual byte %0h file %0h",
               $time, out_byte, out_file_number);
      errors++;
    end else begin
      want = carved_q.pop_front();
      check_field("out_byte", 16'(want.data), 16'(out_byte));
      check_field("out_file_start", 16'(want.starts), 16'(out_file_start));
      check_field("out_file_end", 16'(want.ends), 16'(out_file_end));
      check_field("out_forced_end", 16'(want.forced), 16'(out_forced_end));
      check_field("out_file_number", want.number, out_file_number);
      check_field("out_last", 16'(want.last), 16'(out_last));
    end
  endtask

  // Results leave only after their byte is registered, so compare before predicting
  always @(posedge clk) begin
    if (!rst_n) begin
      history    = '0;
      carving    = 1'b0;
      prev_zero  = 1'b0;
      size_count = '0;
      file_count = '0;
      size_limit = MAX_SIZE_RST;
      carved_q.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) size_limit = cfg_data;
      if (in_valid && in_ready) carve_byte(in_data_byte);
    end
    bytes_owed <= carved_q.size();
  end

endmodule

// ----- test/gif_header_footer_carver_unit_tb.sv -----
// Testbench top for gif_header_footer_carver_unit: drives image bytes, size
// limit writes and result back-pressure, and gives the verdict.
// Depends on gif_hfc_pkg and the gif_hfc_carve_checker module.
module gif_header_footer_carver_unit_tb
  import gif_hfc_pkg::*;
();

  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_file_start;
  logic        out_file_end;
  logic        out_forced_end;
  logic [15:0] out_file_number;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        steady = 1'b0;
  int          mismatches;
  int          bytes_owed;
  int unsigned quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gif_header_footer_carver_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_file_start  (out_file_start),
    .out_file_end    (out_file_end),
    .out_forced_end  (out_forced_end),
    .out_file_number (out_file_number),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  gif_hfc_carve_checker carve_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_file_start  (out_file_start),
    .out_file_end    (out_file_end),
    .out_forced_end  (out_forced_end),
    .out_file_number (out_file_number),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .bytes_owed      (bytes_owed)
  );

  // Abort when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(7);
  endfunction

  function automatic logic [7:0] signature_byte(input int idx, input logic [7:0] ver);
    case (idx)
      0: return CHAR_G;
      1: return CHAR_I;
      2: return CHAR_F;
      3: return CHAR_8;
      4: return ver;
      default: return CHAR_A;
    endcase
  endfunction

  // Favor zero and trailer bytes so trailers form by chance
  function automatic logic [7:0] body_byte();
    case ($urandom_range(7))
      0: return BYTE_ZERO;
      1: return BYTE_TRAILER;
      2: return CHAR_G;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Result side: hold out_ready low for a random stretch before each transaction
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Called at a clock edge; returns at the edge that takes the byte, valid still high
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_header(input logic [7:0] ver);
    for (int i = 0; i < 6; i++) send_byte(signature_byte(i, ver));
  endtask

  // Drain every owed result, let the block settle, then write the limit
  task automatic write_limit(input logic [15:0] limit);
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_mix(input int budget);
    int          sent;
    int          n;
    int          cut;
    logic [7:0]  ver;
    sent = 0;
    while (sent < budget) begin
      ver = $urandom_range(1) ? CHAR_9 : CHAR_7;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          send_header(ver);
          n = $urandom_range(20);
          repeat (n) send_byte(body_byte());
          if ($urandom_range(1)) begin
            send_byte(BYTE_ZERO);
            send_byte(BYTE_TRAILER);
            n += 2;
          end
          sent += 6 + n;
        end
        6, 7: begin
          n = $urandom_range(5, 1);
          repeat (n) send_byte(8'($urandom_range(255)));
          sent += n;
        end
        default: begin
          // break the signature partway with a wrong byte
          cut = $urandom_range(5, 1);
          for (int i = 0; i < cut; i++) send_byte(signature_byte(i, ver));
          send_byte(signature_byte(cut, ver) ^ 8'($urandom_range(255, 1)));
          sent += cut + 1;
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] limit;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: noise, a broken signature, a doubled G before a header,
    // an unarmed trailer byte right after the header, a header inside a file
    send_byte(BYTE_ZERO);
    send_byte(8'hFF);
    send_byte(CHAR_G);
    send_byte(CHAR_I);
    send_byte(CHAR_F);
    send_byte(CHAR_8);
    send_byte(CHAR_7);
    send_byte(8'h62);
    send_byte(CHAR_G);
    send_header(CHAR_7);
    send_byte(BYTE_TRAILER);
    send_header(CHAR_9);
    send_byte(8'hFF);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_TRAILER);

    // Small limits, down to zero
    write_limit(16'd0);
    send_header(CHAR_7);
    send_byte(BYTE_TRAILER);
    write_limit(16'd5);
    send_header(CHAR_9);
    send_byte(8'h80);
    write_limit(16'd6);
    send_header(CHAR_7);
    send_byte(8'h01);
    // a real trailer wins over the limit on the same byte
    write_limit(16'd7);
    send_header(CHAR_9);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_TRAILER);

    repeat (3) begin
      case ($urandom_range(3))
        0: limit = 16'($urandom_range(5));
        1, 2: limit = 16'($urandom_range(40, 6));
        default: limit = 16'($urandom_range(16'hFFFF));
      endcase
      write_limit(limit);
      steady <= ($urandom_range(3) == 0);
      run_mix(25);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && bytes_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gif_hfc_pkg.sv
sv/gif_header_footer_carver_unit.sv
test/gif_hfc_carve_checker.sv
test/gif_header_footer_carver_unit_tb.sv
